// ===== hw/rtl/rph_pkg.sv =====
// ----------------------------------------------------------------------------
// rph_pkg: shared constants and helpers for the ray pad hit test
// Fixed-point widths, register indexes, CORDIC arctangent table, field unpack.
// ----------------------------------------------------------------------------
package rph_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_PLANE_NORMAL   = 3'd0;
  localparam logic [2:0] REG_PLANE_CENTER   = 3'd1;
  localparam logic [2:0] REG_PAD_X_AXIS     = 3'd2;
  localparam logic [2:0] REG_PAD_Y_AXIS     = 3'd3;
  localparam logic [2:0] REG_PAD_HALF       = 3'd4;
  localparam logic [2:0] REG_FRAME_WIDTH    = 3'd5;
  localparam logic [2:0] REG_CONTACTS_WIDTH = 3'd6;
  localparam logic [2:0] REG_ACTIVE_HALF    = 3'd7;

  // Register reset values
  localparam logic [62:0] NORMAL_RST = 63'h2000_0000_0000_0000;
  localparam logic [62:0] CENTER_RST = 63'd0;
  localparam logic [62:0] XAXIS_RST  = 63'd1572864;
  localparam logic [62:0] YAXIS_RST  = 63'h100_0000_0000;
  localparam logic [19:0] PAD_HALF_RST       = 20'd512;
  localparam logic [19:0] FRAME_WIDTH_RST    = 20'd143;
  localparam logic [19:0] CONTACTS_WIDTH_RST = 20'd184;
  localparam logic [19:0] ACTIVE_HALF_RST    = 20'd512;

  // CORDIC
  localparam int CORDIC_ITERS = 20;
  localparam int CORDIC_LAT   = CORDIC_ITERS + 1;
  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;

  // Divider: one overflow check stage, then one quotient bit per stage
  localparam int DIV_BITS = 41;
  localparam int DIV_LAT  = DIV_BITS + 1;
  localparam logic [40:0] T_MAX = 41'h100_0000_0000;

  // Crossing parameter t is clamped at 2^40; arctangent steps in 2^-32 turn
  function automatic logic signed [31:0] atan_val(input int i);
    logic signed [31:0] r;
    unique case (i)
      0:  r = 32'sd536870912;
      1:  r = 32'sd316933406;
      2:  r = 32'sd167458907;
      3:  r = 32'sd85004756;
      4:  r = 32'sd42667331;
      5:  r = 32'sd21354465;
      6:  r = 32'sd10679838;
      7:  r = 32'sd5340245;
      8:  r = 32'sd2670163;
      9:  r = 32'sd1335087;
      10: r = 32'sd667544;
      11: r = 32'sd333772;
      12: r = 32'sd166886;
      13: r = 32'sd83443;
      14: r = 32'sd41722;
      15: r = 32'sd20861;
      16: r = 32'sd10430;
      17: r = 32'sd5215;
      18: r = 32'sd2608;
      19: r = 32'sd1304;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // One signed 21-bit lane of a packed x,y,z vector
  function automatic logic signed [20:0] fld(input logic [62:0] v, input int k);
    return $signed(v[k*21 +: 21]);
  endfunction

  // Round a CORDIC register to Q1.19 and clamp to +-1.0
  function automatic logic signed [20:0] cordic_round(input logic signed [32:0] v);
    logic signed [33:0] r;
    r = (34'(v) + 34'sd1024) >>> 11;
    if (r > 34'sd524288) begin
      return 21'sd524288;
    end else if (r < -34'sd524288) begin
      return -21'sd524288;
    end
    return r[20:0];
  endfunction

  // Saturate to the signed 21-bit output range
  function automatic logic signed [20:0] sat21(input logic signed [63:0] v);
    if (v > 64'sd1048575) begin
      return 21'sd1048575;
    end else if (v < -64'sd1048576) begin
      return -21'sd1048576;
    end
    return v[20:0];
  endfunction

endpackage

// ===== hw/rtl/rph_cordic.sv =====
// ----------------------------------------------------------------------------
// rph_cordic: pipelined rotation CORDIC for cosine and sine
// One iteration per stage, then rounding to Q1.19 and quadrant fold.
// ----------------------------------------------------------------------------
module rph_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic [15:0]        angle_i,
  output logic signed [20:0] cos_o,
  output logic signed [20:0] sin_o
);

  localparam int N = rph_pkg::CORDIC_ITERS;

  logic signed [32:0] x_r [N];
  logic signed [32:0] y_r [N];
  logic signed [31:0] z_r [N];
  logic [1:0]         q_r [N];

  // Iteration stages
  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [31:0] ATAN = rph_pkg::atan_val(i);
    logic signed [32:0] xi, yi, x_nxt, y_nxt;
    logic signed [31:0] zi, z_nxt;
    logic [1:0]         qi;

    if (i == 0) begin : g_first
      assign xi = rph_pkg::CORDIC_X0;
      assign yi = 33'sd0;
      assign zi = $signed({2'b00, angle_i[13:0], 16'd0});
      assign qi = angle_i[15:14];
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign qi = q_r[i-1];
    end

    always_comb begin
      if (zi >= 32'sd0) begin
        x_nxt = xi - (yi >>> i);
        y_nxt = yi + (xi >>> i);
        z_nxt = zi - ATAN;
      end else begin
        x_nxt = xi + (yi >>> i);
        y_nxt = yi - (xi >>> i);
        z_nxt = zi + ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i] <= x_nxt;
        y_r[i] <= y_nxt;
        z_r[i] <= z_nxt;
        q_r[i] <= qi;
      end
    end
  end

  // Round, clamp and fold into the quadrant
  logic signed [20:0] cc, ss, cos_nxt, sin_nxt;
  logic signed [20:0] cos_r, sin_r;

  always_comb begin
    cc = rph_pkg::cordic_round(x_r[N-1]);
    ss = rph_pkg::cordic_round(y_r[N-1]);
    unique case (q_r[N-1])
      2'd0: begin
        cos_nxt = cc;
        sin_nxt = ss;
      end
      2'd1: begin
        cos_nxt = -ss;
        sin_nxt = cc;
      end
      2'd2: begin
        cos_nxt = -cc;
        sin_nxt = -ss;
      end
      default: begin
        cos_nxt = ss;
        sin_nxt = -cc;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// ===== hw/rtl/rph_divider.sv =====
// ----------------------------------------------------------------------------
// rph_divider: pipelined restoring divider for the crossing parameter
// Quotient of (num << 19) / den, one bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module rph_divider (
  input  logic        clk,
  input  logic        en,
  input  logic [42:0] num_i,
  input  logic [40:0] den_i,
  output logic [40:0] quo_o,
  output logic        ovf_o
);

  localparam int N = rph_pkg::DIV_BITS;

  logic [40:0] rem_r  [N+1];
  logic [40:0] bits_r [N+1];
  logic [40:0] quo_r  [N+1];
  logic [40:0] den_r  [N+1];
  logic        ovf_r  [N+1];

  // First stage: dividend bits above the quotient window decide overflow
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {20'd0, num_i[42:22]};
      bits_r[0] <= {num_i[21:0], 19'd0};
      quo_r[0]  <= '0;
      den_r[0]  <= den_i;
      ovf_r[0]  <= {20'd0, num_i[42:22]} >= den_i;
    end
  end

  // Quotient bit stages
  for (genvar j = 1; j <= N; j++) begin : g_step
    logic [41:0] rem2;
    logic        ge;
    logic [40:0] rem_nxt;

    always_comb begin
      rem2    = {rem_r[j-1], bits_r[j-1][40]};
      ge      = rem2 >= {1'b0, den_r[j-1]};
      rem_nxt = ge ? 41'(rem2 - {1'b0, den_r[j-1]}) : rem2[40:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        bits_r[j] <= {bits_r[j-1][39:0], 1'b0};
        quo_r[j]  <= {quo_r[j-1][39:0], ge};
        den_r[j]  <= den_r[j-1];
        ovf_r[j]  <= ovf_r[j-1];
      end
    end
  end

  assign quo_o = quo_r[N];
  assign ovf_o = ovf_r[N];

endmodule

// ===== hw/rtl/ray_pad_hit_test.sv =====
// ----------------------------------------------------------------------------
// ray_pad_hit_test: ray against pad plane, frame and active-area hit test
// Pipelined CORDIC, plane crossing, divider, projection and flag logic.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one ray request per accepted cycle: polar and
//   azimuth angle codes plus a start point. Output channel (out_*): one
//   result per request, in order: two hit flags, pad-frame coordinates and
//   lab hit point.
//   Configuration (cfg_*): write pose and dimension registers while no
//   request is in flight; they are read directly by the pipeline.
//   The pipeline has 21 CORDIC stages, 5 for direction and dot products, 42
//   for the divider (overflow check plus one quotient bit per stage) and 7
//   for offset, projection and flags.
//   Throughput is one request per cycle while out_stall does not freeze it.
//   The whole pipeline moves on one enable: when a result is held by
//   out_stall, every stage freezes and in_stall is raised; nothing is lost
//   or repeated. Empty stages are not squeezed out during a stall.
//   Reset clears the valid bits and loads the default pose: normal along z,
//   centre at the origin, pad x axis along -x and y axis along +y.
// ----------------------------------------------------------------------------
module ray_pad_hit_test (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [62:0]        cfg_wdata,
  // ray requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_polar_angle,
  input  logic [15:0]        in_azimuth_angle,
  input  logic signed [20:0] in_start_x,
  input  logic signed [20:0] in_start_y,
  input  logic signed [20:0] in_start_z,
  // results
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit_frame,
  output logic               out_hit_active,
  output logic signed [20:0] out_pad_x,
  output logic signed [20:0] out_pad_y,
  output logic signed [20:0] out_lab_x,
  output logic signed [20:0] out_lab_y,
  output logic signed [20:0] out_lab_z
);

  localparam int CL    = rph_pkg::CORDIC_LAT;
  localparam int DL    = rph_pkg::DIV_LAT;
  localparam int T_IDX = CL + 5 + DL;
  localparam int LAT   = T_IDX + 7;

  typedef struct packed {
    logic [62:0] p0;
    logic [62:0] dir;
    logic        neg;
    logic        den0;
  } side_t;

  // Configuration registers
  logic [62:0] normal_r, center_r, xaxis_r, yaxis_r;
  logic [19:0] pad_half_r, frame_width_r, contacts_width_r, active_half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r         <= rph_pkg::NORMAL_RST;
      center_r         <= rph_pkg::CENTER_RST;
      xaxis_r          <= rph_pkg::XAXIS_RST;
      yaxis_r          <= rph_pkg::YAXIS_RST;
      pad_half_r       <= rph_pkg::PAD_HALF_RST;
      frame_width_r    <= rph_pkg::FRAME_WIDTH_RST;
      contacts_width_r <= rph_pkg::CONTACTS_WIDTH_RST;
      active_half_r    <= rph_pkg::ACTIVE_HALF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rph_pkg::REG_PLANE_NORMAL:   normal_r         <= cfg_wdata;
        rph_pkg::REG_PLANE_CENTER:   center_r         <= cfg_wdata;
        rph_pkg::REG_PAD_X_AXIS:     xaxis_r          <= cfg_wdata;
        rph_pkg::REG_PAD_Y_AXIS:     yaxis_r          <= cfg_wdata;
        rph_pkg::REG_PAD_HALF:       pad_half_r       <= cfg_wdata[19:0];
        rph_pkg::REG_FRAME_WIDTH:    frame_width_r    <= cfg_wdata[19:0];
        rph_pkg::REG_CONTACTS_WIDTH: contacts_width_r <= cfg_wdata[19:0];
        rph_pkg::REG_ACTIVE_HALF:    active_half_r    <= cfg_wdata[19:0];
      endcase
    end
  end

  // Pipeline enable and valid bits
  logic           pipe_en;
  logic [LAT-1:0] vld_r;

  assign pipe_en  = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !pipe_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Sine and cosine of both angles
  logic signed [20:0] cp, sp, ca, sa;

  rph_cordic u_polar (
    .clk     (clk),
    .en      (pipe_en),
    .angle_i (in_polar_angle),
    .cos_o   (cp),
    .sin_o   (sp)
  );

  rph_cordic u_azimuth (
    .clk     (clk),
    .en      (pipe_en),
    .angle_i (in_azimuth_angle),
    .cos_o   (ca),
    .sin_o   (sa)
  );

  // Start point travels beside the CORDIC
  logic [62:0] p0_dly_r [CL];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p0_dly_r[0] <= {in_start_z, in_start_y, in_start_x};
      for (int i = 1; i < CL; i++) begin
        p0_dly_r[i] <= p0_dly_r[i-1];
      end
    end
  end

  // Direction products and centre offset
  logic signed [41:0] prodl_r, prodm_r;
  logic signed [20:0] cpa_r;
  logic signed [21:0] diff_r [3];
  logic [62:0]        p0a_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      prodl_r <= sp * ca;
      prodm_r <= sp * sa;
      cpa_r   <= cp;
      p0a_r   <= p0_dly_r[CL-1];
      for (int k = 0; k < 3; k++) begin
        diff_r[k] <= 22'(rph_pkg::fld(center_r, k)) - 22'(rph_pkg::fld(p0_dly_r[CL-1], k));
      end
    end
  end

  // Direction rounded to Q1.19
  logic signed [43:0] rl, rm;
  logic [62:0]        dir_nxt;
  logic [62:0]        dir_r, p0b_r;
  logic signed [21:0] diffb_r [3];

  always_comb begin
    rl      = (44'(prodl_r) + 44'sd262144) >>> 19;
    rm      = (44'(prodm_r) + 44'sd262144) >>> 19;
    dir_nxt = {cpa_r, rm[20:0], rl[20:0]};
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dir_r   <= dir_nxt;
      p0b_r   <= p0a_r;
      diffb_r <= diff_r;
    end
  end

  // Dot product terms
  logic signed [42:0] numt_r [3];
  logic signed [41:0] dent_r [3];
  logic [62:0]        p0c_r, dirc_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        numt_r[k] <= rph_pkg::fld(normal_r, k) * diffb_r[k];
        dent_r[k] <= rph_pkg::fld(normal_r, k) * rph_pkg::fld(dir_r, k);
      end
      p0c_r  <= p0b_r;
      dirc_r <= dir_r;
    end
  end

  // Numerator and denominator sums
  logic signed [44:0] num_r;
  logic signed [43:0] den_r;
  logic [62:0]        p0d_r, dird_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      num_r  <= 45'(numt_r[0]) + 45'(numt_r[1]) + 45'(numt_r[2]);
      den_r  <= 44'(dent_r[0]) + 44'(dent_r[1]) + 44'(dent_r[2]);
      p0d_r  <= p0c_r;
      dird_r <= dirc_r;
    end
  end

  // Magnitudes and sign of the quotient
  logic [44:0] num_abs;
  logic [43:0] den_abs;
  logic [42:0] an_r;
  logic [40:0] ad_r;
  side_t       side_a_r;

  always_comb begin
    num_abs = num_r[44] ? 45'(-num_r) : num_r;
    den_abs = den_r[43] ? 44'(-den_r) : den_r;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      an_r          <= num_abs[42:0];
      ad_r          <= den_abs[40:0];
      side_a_r.p0   <= p0d_r;
      side_a_r.dir  <= dird_r;
      side_a_r.neg  <= num_r[44] ^ den_r[43];
      side_a_r.den0 <= (den_r == 44'sd0);
    end
  end

  // Crossing parameter division
  logic [40:0] quo;
  logic        ovf;
  side_t       side_dly_r [DL];

  rph_divider u_div (
    .clk   (clk),
    .en    (pipe_en),
    .num_i (an_r),
    .den_i (ad_r),
    .quo_o (quo),
    .ovf_o (ovf)
  );

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      side_dly_r[0] <= side_a_r;
      for (int i = 1; i < DL; i++) begin
        side_dly_r[i] <= side_dly_r[i-1];
      end
    end
  end

  // Clamp t; a parallel ray or a crossing behind the start is a miss
  logic [40:0] t_r;
  logic        miss_t_r;
  logic [62:0] p0t_r, dirt_r;
  side_t       side_q;

  assign side_q = side_dly_r[DL-1];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      t_r      <= (ovf || quo > rph_pkg::T_MAX) ? rph_pkg::T_MAX : quo;
      miss_t_r <= side_q.den0 || (side_q.neg && (ovf || quo != 41'd0));
      p0t_r    <= side_q.p0;
      dirt_r   <= side_q.dir;
    end
  end

  // Offset along the ray
  logic signed [62:0] tp_r [3];
  logic               miss_p_r;
  logic [62:0]        p0p_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        tp_r[k] <= $signed({1'b0, t_r}) * rph_pkg::fld(dirt_r, k);
      end
      miss_p_r <= miss_t_r;
      p0p_r    <= p0t_r;
    end
  end

  // Lab hit point
  logic signed [62:0] tr  [3];
  logic signed [42:0] hit_nxt [3];
  logic signed [42:0] hit_r [3];
  logic               miss_h_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tr[k]      = (tp_r[k] + 63'sd262144) >>> 19;
      hit_nxt[k] = 43'(tr[k]) + 43'(rph_pkg::fld(p0p_r, k));
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      hit_r    <= hit_nxt;
      miss_h_r <= miss_p_r;
    end
  end

  // Hit relative to the pad centre
  logic signed [43:0] rel_r  [3];
  logic signed [42:0] hitr_r [3];
  logic               miss_r_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        rel_r[k] <= 44'(hit_r[k]) - 44'(rph_pkg::fld(center_r, k));
      end
      hitr_r   <= hit_r;
      miss_r_r <= miss_h_r;
    end
  end

  // Projection terms on the pad axes
  logic signed [64:0] pxt_w [3];
  logic signed [64:0] pyt_w [3];
  logic signed [63:0] pxt_r [3];
  logic signed [63:0] pyt_r [3];
  logic signed [42:0] hitm_r [3];
  logic               miss_m_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pxt_w[k] = rel_r[k] * rph_pkg::fld(xaxis_r, k);
      pyt_w[k] = rel_r[k] * rph_pkg::fld(yaxis_r, k);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int k = 0; k < 3; k++) begin
        pxt_r[k] <= pxt_w[k][63:0];
        pyt_r[k] <= pyt_w[k][63:0];
      end
      hitm_r   <= hitr_r;
      miss_m_r <= miss_r_r;
    end
  end

  // Projection sums with rounding offset
  logic signed [63:0] pxs_r, pys_r;
  logic signed [42:0] hits_r [3];
  logic               miss_s_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pxs_r    <= pxt_r[0] + pxt_r[1] + pxt_r[2] + 64'sd262144;
      pys_r    <= pyt_r[0] + pyt_r[1] + pyt_r[2] + 64'sd262144;
      hits_r   <= hitm_r;
      miss_s_r <= miss_m_r;
    end
  end

  // Outline and active-area checks, saturation
  logic signed [44:0] px, py;
  logic signed [46:0] px_e, py_e, flim, blim, alim;
  logic               frame_nxt, active_nxt;
  logic               hit_frame_r, hit_active_r;
  logic signed [20:0] pad_x_r, pad_y_r, lab_x_r, lab_y_r, lab_z_r;

  always_comb begin
    px   = 45'(pxs_r >>> 19);
    py   = 45'(pys_r >>> 19);
    px_e = 47'(px);
    py_e = 47'(py);
    flim = $signed(47'(pad_half_r) + 47'(frame_width_r));
    blim = $signed(47'(pad_half_r) + 47'(frame_width_r) + 47'(contacts_width_r));
    alim = $signed(47'(active_half_r));
    frame_nxt  = !miss_s_r && px_e <= flim && px_e >= -flim &&
                 py_e <= flim && py_e >= -blim;
    active_nxt = frame_nxt && px_e <= alim && px_e >= -alim &&
                 py_e <= alim && py_e >= -alim;
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      hit_frame_r  <= frame_nxt;
      hit_active_r <= active_nxt;
      pad_x_r      <= miss_s_r ? 21'sd0 : rph_pkg::sat21(64'(px));
      pad_y_r      <= miss_s_r ? 21'sd0 : rph_pkg::sat21(64'(py));
      lab_x_r      <= frame_nxt ? rph_pkg::sat21(64'(hits_r[0])) : 21'sd0;
      lab_y_r      <= frame_nxt ? rph_pkg::sat21(64'(hits_r[1])) : 21'sd0;
      lab_z_r      <= frame_nxt ? rph_pkg::sat21(64'(hits_r[2])) : 21'sd0;
    end
  end

  assign out_valid      = vld_r[LAT-1];
  assign out_hit_frame  = hit_frame_r;
  assign out_hit_active = hit_active_r;
  assign out_pad_x      = pad_x_r;
  assign out_pad_y      = pad_y_r;
  assign out_lab_x      = lab_x_r;
  assign out_lab_y      = lab_y_r;
  assign out_lab_z      = lab_z_r;

  // Active hit always lies inside the frame
  a_active_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit_active && !out_hit_frame))
    else $error("active hit outside frame");

  // Lab point is zero whenever the frame is missed
  a_lab_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit_frame |->
      out_lab_x == 21'sd0 && out_lab_y == 21'sd0 && out_lab_z == 21'sd0)
    else $error("lab point set without frame hit");

  // Crossing parameter never exceeds its clamp
  a_t_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[T_IDX] |-> t_r <= rph_pkg::T_MAX)
    else $error("crossing parameter above clamp");

  // A request near the end of the pipe reaches the output on the next move
  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_en && vld_r[LAT-2] |=> out_valid)
    else $error("request lost before output stage");

endmodule
